/* rtl/core/nand_block_write_state_tracker_macros.svh */
// ----------------------------------------------------------------------------
// nand_block_write_state_tracker_macros
// Assertion macros for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef NAND_BLOCK_WRITE_STATE_TRACKER_MACROS_SVH
`define NAND_BLOCK_WRITE_STATE_TRACKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NBWST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NBWST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/nbwst_pkg.sv */
// ----------------------------------------------------------------------------
// nbwst_pkg
// Types, codes and defaults shared by the NAND block write state tracker.
// ----------------------------------------------------------------------------
package nbwst_pkg;

   localparam int MAX_BLOCKS_DEF          = 1024;
   localparam int MAX_PAGES_PER_BLOCK_DEF = 256;

   // Width of the flat index accumulator: a larger product is truncated to it.
   localparam int FLAT_W = 19;
   localparam int CSR_W  = 9;
   localparam int CNT_W  = 9;

   localparam logic [2:0] OP_PROGRAM   = 3'd0;
   localparam logic [2:0] OP_MARK_VAL  = 3'd1;
   localparam logic [2:0] OP_MARK_INV  = 3'd2;
   localparam logic [2:0] OP_MARK_FREE = 3'd3;
   localparam logic [2:0] OP_ERASE     = 3'd4;
   localparam logic [2:0] OP_QUERY     = 3'd5;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ORDER     = 3'd1;
   localparam logic [2:0] ST_NOT_WR    = 3'd2;
   localparam logic [2:0] ST_MISMATCH  = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;

   localparam logic [1:0] BS_FREE      = 2'd0;
   localparam logic [1:0] BS_OPEN      = 2'd1;
   localparam logic [1:0] BS_CLOSED    = 2'd2;
   localparam logic [1:0] BS_BAD       = 2'd3;

   localparam logic [1:0] PAGE_FREE    = 2'd0;
   localparam logic [1:0] PAGE_VALID   = 2'd1;
   localparam logic [1:0] PAGE_INVALID = 2'd2;

   localparam logic [2:0] REG_CHANNELS = 3'd0;
   localparam logic [2:0] REG_LUNS     = 3'd1;
   localparam logic [2:0] REG_PLANES   = 3'd2;
   localparam logic [2:0] REG_BLOCKS   = 3'd3;
   localparam logic [2:0] REG_PAGES    = 3'd4;

   localparam logic [CNT_W-1:0] CNT_TOP   = '1;
   localparam logic [31:0]      ERASE_TOP = '1;

   typedef struct packed {
      logic [1:0]       state;
      logic [8:0]       wp;
      logic [31:0]      erase;
      logic [CNT_W-1:0] valid;
      logic [CNT_W-1:0] invalid;
   } block_rec_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } store_ctl_type;

endpackage

/* rtl/core/nbwst_mac.sv */
// ----------------------------------------------------------------------------
// nbwst_mac
// Shared multiply-add unit that folds the address fields into a flat index.
// ----------------------------------------------------------------------------
module nbwst_mac
   import nbwst_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  logic [2:0]        load_val,
   input  logic              step,
   input  logic [8:0]        mul,
   input  logic [7:0]        add,
   output logic [FLAT_W-1:0] acc
);

   logic [FLAT_W-1:0] acc_ff;
   logic [FLAT_W-1:0] acc_in;
   logic [FLAT_W+8:0] prod;

   always_comb begin
      prod   = acc_ff * mul;
      acc_in = acc_ff;
      if (load) begin
         acc_in = FLAT_W'(load_val);
      end else if (step) begin
         acc_in = prod[FLAT_W-1:0] + FLAT_W'(add);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

/* rtl/core/nbwst_store.sv */
// ----------------------------------------------------------------------------
// nbwst_store
// Block record memory and page state row memory, with clearing after reset.
// ----------------------------------------------------------------------------
module nbwst_store
   import nbwst_pkg::*;
#(
   parameter int MAX_BLOCKS          = MAX_BLOCKS_DEF,
   parameter int MAX_PAGES_PER_BLOCK = MAX_PAGES_PER_BLOCK_DEF,
   localparam int BAW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
   localparam int ROW_W = 2 * MAX_PAGES_PER_BLOCK
)
(
   input  logic             clock,
   input  logic             reset,
   input  store_ctl_type    ctl,
   input  logic [BAW-1:0]   addr,
   input  block_rec_type    wr_rec,
   input  logic [ROW_W-1:0] wr_row,
   output block_rec_type    rd_rec,
   output logic [ROW_W-1:0] rd_row,
   output logic             busy
);

   block_rec_type    rec_mem [MAX_BLOCKS];
   logic [ROW_W-1:0] row_mem [MAX_BLOCKS];

   logic             busy_ff, busy_in;
   logic [BAW-1:0]   clr_ff, clr_in;
   logic             we;
   logic [BAW-1:0]   waddr;
   block_rec_type    wrec;
   logic [ROW_W-1:0] wrow;

   always_comb begin
      busy_in = busy_ff;
      clr_in  = clr_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == BAW'(MAX_BLOCKS - 1)) begin
            busy_in = 1'b0;
         end
      end
      we    = busy_ff | ctl.wr;
      waddr = busy_ff ? clr_ff : addr;
      wrec  = busy_ff ? '0 : wr_rec;
      wrow  = busy_ff ? '0 : wr_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_ff  <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         rec_mem[waddr] <= wrec;
         row_mem[waddr] <= wrow;
      end
      if (ctl.rd) begin
         rd_rec <= rec_mem[addr];
         rd_row <= row_mem[addr];
      end
   end

   assign busy = busy_ff;

endmodule

/* rtl/core/nand_block_write_state_tracker.sv */
// ----------------------------------------------------------------------------
// nand_block_write_state_tracker
// Block and page state bookkeeping for a flash translation layer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | content
//  req_    | in        | req_valid/req_stall | op and block/page address
//  rsp_    | out       | rsp_valid/rsp_stall | status and block/page state
//  csr_    | in        | csr_write           | geometry registers
//
// An item passes through a load, three multiply-add steps on the shared
// unit for the flat index, one memory read, and one update and write.
// After reset a clearing pass walks every entry of the stores, with no
// item taken. A held result stalls the update cycle; the block takes the
// next item once the update has been written.
// ----------------------------------------------------------------------------
module nand_block_write_state_tracker
   import nbwst_pkg::*;
#(
   parameter int MAX_BLOCKS          = MAX_BLOCKS_DEF,
   parameter int MAX_PAGES_PER_BLOCK = MAX_PAGES_PER_BLOCK_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [2:0]  req_channel,
   input  logic [2:0]  req_lun,
   input  logic [1:0]  req_plane,
   input  logic [7:0]  req_block,
   input  logic [7:0]  req_page,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_block_state_out,
   output logic        rsp_state_changed,
   output logic [1:0]  rsp_previous_state,
   output logic [8:0]  rsp_write_pointer_out,
   output logic [31:0] rsp_erase_count_out,
   output logic [8:0]  rsp_valid_pages_out,
   output logic [8:0]  rsp_invalid_pages_out,
   output logic [1:0]  rsp_page_state_out,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [CSR_W-1:0] csr_data
);

   localparam int BAW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int PIW   = (MAX_PAGES_PER_BLOCK > 1) ? $clog2(MAX_PAGES_PER_BLOCK) : 1;
   localparam int ROW_W = 2 * MAX_PAGES_PER_BLOCK;
   localparam int EW    = $clog2(MAX_PAGES_PER_BLOCK + 1);
   localparam int PW    = (EW > 9) ? EW : 9;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MAC   = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_EXEC  = 3'd4;

   logic [3:0] channels_ff, luns_ff;
   logic [2:0] planes_ff;
   logic [8:0] blocks_ff, pages_ff;

   logic [2:0] state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic [2:0] op_ff;
   logic [2:0] lun_ff;
   logic [1:0] plane_ff;
   logic [7:0] block_ff, page_ff;
   logic       pg_ok_ff, bad_ff, bad_in;

   logic [PW-1:0] ppb;
   logic          accept, pg_ok_now, bad_now, go;

   logic [FLAT_W-1:0] acc;
   logic              mac_load, mac_step;
   logic [8:0]        mac_mul;
   logic [7:0]        mac_add;

   store_ctl_type    ctl;
   block_rec_type    rd_rec, new_rec;
   logic [ROW_W-1:0] rd_row, new_row;
   logic             busy;

   logic [PIW-1:0] pidx;
   logic [1:0]     cur_pg, pg_out;
   logic [2:0]     status;

   logic        rsp_valid_ff;
   logic [2:0]  status_ff;
   logic [1:0]  bstate_ff, prev_ff, pstate_ff;
   logic        changed_ff;
   logic [8:0]  wp_ff, valid_ff, invalid_ff;
   logic [31:0] erase_ff;

   assign ppb = (PW'(pages_ff) < PW'(MAX_PAGES_PER_BLOCK)) ?
                PW'(pages_ff) : PW'(MAX_PAGES_PER_BLOCK);

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign pg_ok_now = PW'(req_page) < ppb;
   assign bad_now   = ({1'b0, req_channel} >= channels_ff) |
                      ({1'b0, req_lun} >= luns_ff) |
                      ({1'b0, req_plane} >= planes_ff) |
                      ({1'b0, req_block} >= blocks_ff) |
                      ((req_op <= OP_MARK_INV) & ~pg_ok_now);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         channels_ff <= 4'd1;
         luns_ff     <= 4'd1;
         planes_ff   <= 3'd1;
         blocks_ff   <= 9'd1;
         pages_ff    <= 9'd256;
      end else if (csr_write) begin
         case (csr_index)
            REG_CHANNELS: channels_ff <= csr_data[3:0];
            REG_LUNS:     luns_ff     <= csr_data[3:0];
            REG_PLANES:   planes_ff   <= csr_data[2:0];
            REG_BLOCKS:   blocks_ff   <= csr_data[8:0];
            REG_PAGES:    pages_ff    <= csr_data[8:0];
            default: begin
            end
         endcase
      end
   end

   // Multiply-add sequence: ch, then *luns+lun, *planes+plane, *blocks+block.
   always_comb begin
      mac_load = accept;
      mac_step = (state_ff == S_MAC);
      case (step_ff)
         2'd0: begin
            mac_mul = {5'd0, luns_ff};
            mac_add = {5'd0, lun_ff};
         end
         2'd1: begin
            mac_mul = {6'd0, planes_ff};
            mac_add = {6'd0, plane_ff};
         end
         default: begin
            mac_mul = blocks_ff;
            mac_add = block_ff;
         end
      endcase
   end

   nbwst_mac u_mac (
      .clock    (clock),
      .load     (mac_load),
      .load_val (req_channel),
      .step     (mac_step),
      .mul      (mac_mul),
      .add      (mac_add),
      .acc      (acc)
   );

   assign go = (state_ff == S_EXEC) & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      bad_in   = bad_ff;
      ctl      = '0;
      case (state_ff)
         S_CLEAR: begin
            if (!busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_MAC;
               step_in  = 2'd0;
               bad_in   = bad_now;
            end
         end
         S_MAC: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            // Range check on the finished flat index.
            if (acc >= FLAT_W'(MAX_BLOCKS)) begin
               bad_in = 1'b1;
            end
            ctl.rd   = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (go) begin
               ctl.wr   = ~bad_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         step_ff  <= 2'd0;
         bad_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         bad_ff   <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         lun_ff   <= req_lun;
         plane_ff <= req_plane;
         block_ff <= req_block;
         page_ff  <= req_page;
         pg_ok_ff <= pg_ok_now;
      end
   end

   nbwst_store #(
      .MAX_BLOCKS          (MAX_BLOCKS),
      .MAX_PAGES_PER_BLOCK (MAX_PAGES_PER_BLOCK)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .addr   (acc[BAW-1:0]),
      .wr_rec (new_rec),
      .wr_row (new_row),
      .rd_rec (rd_rec),
      .rd_row (rd_row),
      .busy   (busy)
   );

   // Update of the block record and page row.
   always_comb begin
      pidx    = pg_ok_ff ? PIW'(page_ff) : '0;
      new_rec = rd_rec;
      new_row = rd_row;
      status  = ST_OK;
      cur_pg  = rd_row[{pidx, 1'b0} +: 2];
      case (op_ff)
         OP_PROGRAM: begin
            if (rd_rec.state == BS_FREE) begin
               if (page_ff != 8'd0) begin
                  status = ST_ORDER;
               end else begin
                  new_rec.state = BS_OPEN;
                  new_rec.wp    = 9'd1;
                  if (PW'(9'd1) == ppb) begin
                     new_rec.state = BS_CLOSED;
                  end
               end
            end else if (rd_rec.state == BS_OPEN) begin
               if ({1'b0, page_ff} != rd_rec.wp) begin
                  status = ST_ORDER;
               end else begin
                  new_rec.wp = rd_rec.wp + 9'd1;
                  if (PW'(new_rec.wp) == ppb) begin
                     new_rec.state = BS_CLOSED;
                  end
               end
            end else begin
               status = ST_NOT_WR;
            end
         end
         OP_MARK_VAL: begin
            if (cur_pg != PAGE_FREE) begin
               status = ST_MISMATCH;
            end else begin
               new_row[{pidx, 1'b0} +: 2] = PAGE_VALID;
               if (rd_rec.valid != CNT_TOP) begin
                  new_rec.valid = rd_rec.valid + 1'b1;
               end
            end
         end
         OP_MARK_INV: begin
            if (cur_pg != PAGE_VALID) begin
               status = ST_MISMATCH;
            end else begin
               new_row[{pidx, 1'b0} +: 2] = PAGE_INVALID;
               if (rd_rec.valid != '0) begin
                  new_rec.valid = rd_rec.valid - 1'b1;
               end
               if (rd_rec.invalid != CNT_TOP) begin
                  new_rec.invalid = rd_rec.invalid + 1'b1;
               end
            end
         end
         OP_MARK_FREE: begin
            new_row         = '0;
            new_rec.valid   = '0;
            new_rec.invalid = '0;
         end
         OP_ERASE: begin
            new_row         = '0;
            new_rec.valid   = '0;
            new_rec.invalid = '0;
            new_rec.state   = BS_FREE;
            new_rec.wp      = '0;
            if (rd_rec.erase != ERASE_TOP) begin
               new_rec.erase = rd_rec.erase + 32'd1;
            end
         end
         default: begin
         end
      endcase
      pg_out = pg_ok_ff ? new_row[{pidx, 1'b0} +: 2] : PAGE_FREE;
   end

   // Result register: hold while stalled, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         if (bad_ff) begin
            status_ff  <= ST_RANGE;
            bstate_ff  <= '0;
            changed_ff <= 1'b0;
            prev_ff    <= '0;
            wp_ff      <= '0;
            erase_ff   <= '0;
            valid_ff   <= '0;
            invalid_ff <= '0;
            pstate_ff  <= '0;
         end else begin
            status_ff  <= status;
            bstate_ff  <= new_rec.state;
            changed_ff <= (new_rec.state != rd_rec.state);
            prev_ff    <= rd_rec.state;
            wp_ff      <= new_rec.wp;
            erase_ff   <= new_rec.erase;
            valid_ff   <= new_rec.valid;
            invalid_ff <= new_rec.invalid;
            pstate_ff  <= pg_out;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_block_state_out   = bstate_ff;
   assign rsp_state_changed     = changed_ff;
   assign rsp_previous_state    = prev_ff;
   assign rsp_write_pointer_out = wp_ff;
   assign rsp_erase_count_out   = erase_ff;
   assign rsp_valid_pages_out   = valid_ff;
   assign rsp_invalid_pages_out = invalid_ff;
   assign rsp_page_state_out    = pstate_ff;

endmodule

/* rtl/core/nbwst_checker.sv */
// ----------------------------------------------------------------------------
// nbwst_checker
// Port-level checks on the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "nand_block_write_state_tracker_macros.svh"

module nbwst_checker
   import nbwst_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [1:0]  rsp_block_state_out,
   input logic        rsp_state_changed,
   input logic [1:0]  rsp_previous_state,
   input logic [8:0]  rsp_write_pointer_out,
   input logic [31:0] rsp_erase_count_out,
   input logic [8:0]  rsp_valid_pages_out,
   input logic [8:0]  rsp_invalid_pages_out,
   input logic [1:0]  rsp_page_state_out
);

   `NBWST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid,
      "result dropped while stalled")

   `NBWST_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall,
      req_stall, "item taken while previous item in flight")

   `NBWST_ASSERT_SAME(a_range_zero, clock, reset, rsp_valid && rsp_status == ST_RANGE,
      rsp_block_state_out == 2'd0 && !rsp_state_changed && rsp_previous_state == 2'd0 &&
      rsp_write_pointer_out == 9'd0 && rsp_erase_count_out == 32'd0 &&
      rsp_valid_pages_out == 9'd0 && rsp_invalid_pages_out == 9'd0 &&
      rsp_page_state_out == 2'd0, "out of range result not cleared")

   `NBWST_ASSERT_SAME(a_error_no_change, clock, reset,
      rsp_valid && (rsp_status == ST_ORDER || rsp_status == ST_NOT_WR ||
      rsp_status == ST_MISMATCH),
      !rsp_state_changed && rsp_block_state_out == rsp_previous_state,
      "rejected item changed block state")

endmodule

bind nand_block_write_state_tracker nbwst_checker u_nbwst_checker (.*);
